[hdl/cor_pkg.sv]
// ----------------------------------------------------------------------------
// cor_pkg
// shared sizes and types for the cluster outlier replacement filter
// ----------------------------------------------------------------------------
package cor_pkg;

   localparam int MAX_SAMPLES = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int IDX_BITS    = $clog2(MAX_SAMPLES);
   localparam int CNT_BITS    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS    = SAMPLE_BITS + IDX_BITS;
   localparam int DIV_BITS    = SUM_BITS + 8;
   localparam int STEP_BITS   = $clog2(DIV_BITS + 1);
   localparam int MEAN_BITS   = SAMPLE_BITS + 8;
   localparam int GAP_BITS    = 16;
   localparam logic [GAP_BITS-1:0] GAP_RESET = GAP_BITS'(8);

   typedef struct packed {
      logic insert;
      logic shift;
   } sort_ctrl_type;

   typedef struct packed {
      logic                       start;
      logic signed [DIV_BITS-1:0] num;
      logic [CNT_BITS-1:0]        den;
   } div_req_type;

endpackage

[hdl/cor_ram.sv]
// ----------------------------------------------------------------------------
// cor_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module cor_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/cor_sorter.sv]
// ----------------------------------------------------------------------------
// cor_sorter
// row of cells kept in ascending order by insertion, drained from the head
// ----------------------------------------------------------------------------
module cor_sorter (
   input  logic                                 clock,
   input  cor_pkg::sort_ctrl_type               ctrl,
   input  logic [cor_pkg::CNT_BITS-1:0]         count,
   input  logic signed [cor_pkg::SAMPLE_BITS-1:0] in_value,
   output logic signed [cor_pkg::SAMPLE_BITS-1:0] head
);

   logic signed [cor_pkg::SAMPLE_BITS-1:0] cell_ff [cor_pkg::MAX_SAMPLES];
   logic signed [cor_pkg::SAMPLE_BITS-1:0] cell_in [cor_pkg::MAX_SAMPLES];
   logic [cor_pkg::MAX_SAMPLES-1:0]        gt;

   always_comb begin
      for (int k = 0; k < cor_pkg::MAX_SAMPLES; k++) begin
         gt[k] = (cor_pkg::CNT_BITS'(k) < count) && (cell_ff[k] > in_value);
      end
      for (int k = 0; k < cor_pkg::MAX_SAMPLES; k++) begin
         cell_in[k] = cell_ff[k];
         if (ctrl.shift) begin
            if (k < cor_pkg::MAX_SAMPLES - 1) begin
               cell_in[k] = cell_ff[k + 1];
            end
         end else if (ctrl.insert) begin
            // cells below the insert point and beyond the fill stay put
            if (cor_pkg::CNT_BITS'(k) < count && !gt[k]) begin
               cell_in[k] = cell_ff[k];
            end else if (cor_pkg::CNT_BITS'(k) > count) begin
               cell_in[k] = cell_ff[k];
            end else if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
               cell_in[k] = cell_ff[(k > 0) ? k - 1 : 0];
            end else begin
               cell_in[k] = in_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < cor_pkg::MAX_SAMPLES; k++) begin
         cell_ff[k] <= cell_in[k];
      end
   end

   assign head = cell_ff[0];

endmodule

[hdl/cor_divider.sv]
// ----------------------------------------------------------------------------
// cor_divider
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module cor_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  cor_pkg::div_req_type                req,
   output logic                                done,
   output logic signed [cor_pkg::DIV_BITS-1:0] quot
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic                            neg_ff, neg_in;
   logic [cor_pkg::STEP_BITS-1:0]   step_ff, step_in;
   logic [cor_pkg::DIV_BITS-1:0]    dvd_ff, dvd_in;
   logic [cor_pkg::CNT_BITS-1:0]    rem_ff, rem_in;
   logic [cor_pkg::CNT_BITS-1:0]    den_ff, den_in;
   logic [cor_pkg::CNT_BITS:0]      rem_sh;
   logic [cor_pkg::CNT_BITS:0]      rem_sub;
   logic                            ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff, dvd_ff[cor_pkg::DIV_BITS-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      ge      = rem_sh >= {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         neg_in  = req.num[cor_pkg::DIV_BITS-1];
         dvd_in  = req.num[cor_pkg::DIV_BITS-1] ? -req.num : req.num;
         rem_in  = '0;
         den_in  = req.den;
         step_in = cor_pkg::STEP_BITS'(cor_pkg::DIV_BITS);
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sub[cor_pkg::CNT_BITS-1:0] : rem_sh[cor_pkg::CNT_BITS-1:0];
         dvd_in  = {dvd_ff[cor_pkg::DIV_BITS-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == cor_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(dvd_ff) : $signed(dvd_ff);

endmodule

[hdl/cluster_outlier_replace_filter.sv]
// ----------------------------------------------------------------------------
// cluster_outlier_replace_filter
// majority-run outlier replacement over a window of signed samples
// ----------------------------------------------------------------------------
// usage
//   req channel: one sample per beat, req_last_sample closes the window; a
//   window also closes by itself when it reaches MAX_SAMPLES samples.
//   samples load at one per cycle while the block is in its load phase.
//   after the window closes req_ready stays low until every result beat of
//   that window has been taken on the rsp channel.
//   per window: the samples load, the sort row drains while runs are found,
//   the final run closes, the divider forms the majority mean, the filtered
//   samples accumulate from the sample memory, the divider forms the Q8
//   mean, then each result beat takes a memory read, a load and a handshake.
//   the divider yields one quotient bit per cycle; the sample memory has a
//   single read port, read once per sample to accumulate and once to emit.
//   rsp beats come in input order, last_result on the final one.
//   a stalled receiver simply holds the current result beat in place.
//   reset: cluster_gap returns to 8, the window is emptied; the sample
//   memory is not cleared, since only entries of the current window are read.
//   csr_write_enable updates cluster_gap at once; write only while idle.
// ----------------------------------------------------------------------------
module cluster_outlier_replace_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [cor_pkg::GAP_BITS-1:0]          csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [cor_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                                  req_last_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [cor_pkg::SAMPLE_BITS-1:0] rsp_filtered_value,
   output logic [cor_pkg::IDX_BITS-1:0]          rsp_position,
   output logic                                  rsp_is_outlier,
   output logic signed [cor_pkg::MEAN_BITS-1:0]  rsp_window_mean_q8,
   output logic                                  rsp_last_result
);

   typedef enum logic [3:0] {
      ST_LOAD, ST_SCAN, ST_CLOSE, ST_DIV1, ST_DIV1_WAIT, ST_ACC_RD, ST_ACC_USE,
      ST_DIV2, ST_DIV2_WAIT, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_HOLD
   } state_type;

   localparam int SB = cor_pkg::SAMPLE_BITS;
   localparam int CB = cor_pkg::CNT_BITS;
   localparam int IB = cor_pkg::IDX_BITS;
   localparam int UB = cor_pkg::SUM_BITS;

   state_type                    state_ff, state_in;
   logic [cor_pkg::GAP_BITS-1:0] gap_ff;
   logic [CB-1:0]                cnt_ff, cnt_in;      // samples in window
   logic [CB-1:0]                idx_ff, idx_in;      // scan / read position
   logic signed [SB-1:0]         prev_ff, prev_in;
   logic [CB-1:0]                cur_len_ff, cur_len_in;
   logic signed [UB-1:0]         cur_sum_ff, cur_sum_in;
   logic signed [SB-1:0]         cur_low_ff, cur_low_in;
   logic [CB-1:0]                best_len_ff, best_len_in;
   logic signed [UB-1:0]         best_sum_ff, best_sum_in;
   logic signed [SB-1:0]         best_low_ff, best_low_in;
   logic signed [SB-1:0]         best_high_ff, best_high_in;
   logic signed [SB-1:0]         maj_mean_ff, maj_mean_in;
   logic signed [UB-1:0]         total_ff, total_in;
   logic signed [cor_pkg::MEAN_BITS-1:0] mean_ff, mean_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]         rsp_value_ff, rsp_value_in;
   logic [IB-1:0]                rsp_pos_ff, rsp_pos_in;
   logic                         rsp_outl_ff, rsp_outl_in;
   logic                         rsp_last_ff, rsp_last_in;

   cor_pkg::sort_ctrl_type       sort_ctrl;
   cor_pkg::div_req_type         div_req;
   logic signed [SB-1:0]         head;
   logic                         div_done;
   logic signed [cor_pkg::DIV_BITS-1:0] div_quot;
   logic                         ram_rd_en;
   logic [IB-1:0]                ram_rd_addr;
   logic [SB-1:0]                ram_rd_data;
   logic signed [SB-1:0]         mem_value;
   logic                         req_fire;
   logic signed [SB:0]           diff;
   logic                         split;
   logic                         outl;
   logic signed [SB-1:0]         filt;

   assign req_fire  = req_valid && req_ready;
   assign mem_value = $signed(ram_rd_data);
   assign diff      = {head[SB-1], head} - {prev_ff[SB-1], prev_ff};
   // diff is never negative in sorted order
   assign split     = $unsigned(diff) > (SB + 1)'(gap_ff);
   assign outl      = (mem_value < best_low_ff) || (mem_value > best_high_ff);
   assign filt      = outl ? maj_mean_ff : mem_value;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= cor_pkg::GAP_RESET;
      end else if (csr_write_enable) begin
         gap_ff <= csr_write_data;
      end
   end

   cor_ram #(
      .WIDTH(SB),
      .DEPTH(cor_pkg::MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (cnt_ff[IB-1:0]),
      .wr_data (req_sample_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cor_sorter u_sorter (
      .clock    (clock),
      .ctrl     (sort_ctrl),
      .count    (cnt_ff),
      .in_value (req_sample_value),
      .head     (head)
   );

   cor_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      cur_len_in   = cur_len_ff;
      cur_sum_in   = cur_sum_ff;
      cur_low_in   = cur_low_ff;
      best_len_in  = best_len_ff;
      best_sum_in  = best_sum_ff;
      best_low_in  = best_low_ff;
      best_high_in = best_high_ff;
      maj_mean_in  = maj_mean_ff;
      total_in     = total_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_outl_in  = rsp_outl_ff;
      rsp_last_in  = rsp_last_ff;
      sort_ctrl    = '0;
      div_req      = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff[IB-1:0];
      req_ready    = (state_ff == ST_LOAD);

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               sort_ctrl.insert = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               // a full store closes the window even without the mark
               if (req_last_sample || cnt_in == CB'(cor_pkg::MAX_SAMPLES)) begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            sort_ctrl.shift = 1'b1;
            prev_in = head;
            if (idx_ff == '0) begin
               cur_len_in  = CB'(1);
               cur_sum_in  = UB'(head);
               cur_low_in  = head;
               best_len_in = '0;
            end else if (split) begin
               if (cur_len_ff > best_len_ff) begin
                  best_len_in  = cur_len_ff;
                  best_sum_in  = cur_sum_ff;
                  best_low_in  = cur_low_ff;
                  best_high_in = prev_ff;
               end
               cur_len_in = CB'(1);
               cur_sum_in = UB'(head);
               cur_low_in = head;
            end else begin
               cur_len_in = cur_len_ff + 1'b1;
               cur_sum_in = cur_sum_ff + UB'(head);
            end
            idx_in = idx_ff + 1'b1;
            if (idx_in == cnt_ff) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            // close the final run
            if (cur_len_ff > best_len_ff) begin
               best_len_in  = cur_len_ff;
               best_sum_in  = cur_sum_ff;
               best_low_in  = cur_low_ff;
               best_high_in = prev_ff;
            end
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            div_req.start = 1'b1;
            div_req.num   = cor_pkg::DIV_BITS'(best_sum_ff);
            div_req.den   = best_len_ff;
            state_in      = ST_DIV1_WAIT;
         end
         ST_DIV1_WAIT: begin
            if (div_done) begin
               maj_mean_in = div_quot[SB-1:0];
               total_in    = '0;
               idx_in      = '0;
               state_in    = ST_ACC_RD;
            end
         end
         ST_ACC_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_ACC_USE;
         end
         ST_ACC_USE: begin
            total_in = total_ff + UB'(filt);
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_in == cnt_ff) ? ST_DIV2 : ST_ACC_RD;
         end
         ST_DIV2: begin
            div_req.start = 1'b1;
            div_req.num   = cor_pkg::DIV_BITS'(total_ff) <<< 8;
            div_req.den   = cnt_ff;
            state_in      = ST_DIV2_WAIT;
         end
         ST_DIV2_WAIT: begin
            if (div_done) begin
               mean_in  = div_quot[cor_pkg::MEAN_BITS-1:0];
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = filt;
            rsp_pos_in   = idx_ff[IB-1:0];
            rsp_outl_in  = outl;
            rsp_last_in  = (idx_ff + 1'b1) == cnt_ff;
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            // beat holds until the receiver takes it
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               idx_in       = idx_ff + 1'b1;
               if (rsp_last_ff) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      prev_ff      <= prev_in;
      cur_len_ff   <= cur_len_in;
      cur_sum_ff   <= cur_sum_in;
      cur_low_ff   <= cur_low_in;
      best_len_ff  <= best_len_in;
      best_sum_ff  <= best_sum_in;
      best_low_ff  <= best_low_in;
      best_high_ff <= best_high_in;
      maj_mean_ff  <= maj_mean_in;
      total_ff     <= total_in;
      mean_ff      <= mean_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_outl_ff  <= rsp_outl_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_is_outlier     = rsp_outl_ff;
   assign rsp_window_mean_q8 = mean_ff;
   assign rsp_last_result    = rsp_last_ff;

   // no sample is taken while a result beat is pending
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("sample accepted while result pending");

   // window never grows past the store
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CB'(cor_pkg::MAX_SAMPLES))
      else $error("window count overflow");

   // a majority run exists before any sample is filtered
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC_USE |-> best_len_ff != '0 && best_len_ff <= cnt_ff)
      else $error("majority run size out of range");

   // taking the last beat of a window reopens the input
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_result |=> req_ready)
      else $error("input not reopened after window");

endmodule

[bench/cor_checker.sv]
// ----------------------------------------------------------------------------
// cor_checker
// watches both channels, predicts each window's result beats, compares them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cor_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [cor_pkg::GAP_BITS-1:0]           csr_write_data,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [cor_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                                   req_last_sample,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [cor_pkg::SAMPLE_BITS-1:0] rsp_filtered_value,
   input  logic [cor_pkg::IDX_BITS-1:0]           rsp_position,
   input  logic                                   rsp_is_outlier,
   input  logic signed [cor_pkg::MEAN_BITS-1:0]   rsp_window_mean_q8,
   input  logic                                   rsp_last_result,
   output int                                     mismatch_count,
   output int                                     pending_beats,
   output int                                     beats_seen,
   output int                                     windows_closed,
   output int                                     outliers_seen
);
   import cor_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filtered;
      logic [IDX_BITS-1:0]           position;
      logic                          outlier;
      logic signed [MEAN_BITS-1:0]   mean_q8;
      logic                          last;
   } filter_beat_type;

   filter_beat_type        expected_beats[$];
   logic [GAP_BITS-1:0]    gap_setting;
   longint                 window_samples[MAX_SAMPLES];
   int                     fill_count;

   assign pending_beats = expected_beats.size();

   task automatic close_window();
      longint          ordered[MAX_SAMPLES];
      longint          held, run_sum, majority_mean, filtered_total, mean_q8;
      longint          low_value, high_value;
      int              k, m, best_start, best_len, run_start;
      logic            marked;
      filter_beat_type beat;
      begin
         for (k = 0; k < fill_count; k++) ordered[k] = window_samples[k];
         for (k = 1; k < fill_count; k++) begin
            held = ordered[k];
            m = k;
            while (m > 0 && ordered[m-1] > held) begin
               ordered[m] = ordered[m-1];
               m--;
            end
            ordered[m] = held;
         end
         best_start = 0;
         best_len = 0;
         run_start = 0;
         for (k = 1; k <= fill_count; k++) begin
            if (k == fill_count || ordered[k] - ordered[k-1] > longint'(gap_setting)) begin
               if (k - run_start > best_len) begin
                  best_len = k - run_start;
                  best_start = run_start;
               end
               run_start = k;
            end
         end
         low_value = ordered[best_start];
         high_value = ordered[best_start + best_len - 1];
         run_sum = 0;
         for (k = 0; k < best_len; k++) run_sum += ordered[best_start + k];
         majority_mean = run_sum / best_len;
         filtered_total = 0;
         for (k = 0; k < fill_count; k++) begin
            marked = window_samples[k] < low_value || window_samples[k] > high_value;
            filtered_total += marked ? majority_mean : window_samples[k];
         end
         mean_q8 = (filtered_total * 256) / fill_count;
         for (k = 0; k < fill_count; k++) begin
            marked = window_samples[k] < low_value || window_samples[k] > high_value;
            beat.filtered = marked ? SAMPLE_BITS'(majority_mean)
                                   : SAMPLE_BITS'(window_samples[k]);
            beat.position = IDX_BITS'(k);
            beat.outlier  = marked;
            beat.mean_q8  = MEAN_BITS'(mean_q8);
            beat.last     = (k == fill_count - 1);
            expected_beats.push_back(beat);
         end
         fill_count = 0;
      end
   endtask

   always @(posedge clock) begin
      filter_beat_type seen, want;
      if (reset) begin
         gap_setting = GAP_RESET;
         fill_count = 0;
         expected_beats.delete();
         mismatch_count = 0;
         beats_seen = 0;
         windows_closed = 0;
         outliers_seen = 0;
      end else begin
         if (csr_write_enable) gap_setting = csr_write_data;
         if (req_valid && req_ready) begin
            window_samples[fill_count] = longint'(req_sample_value);
            fill_count++;
            if (req_last_sample || fill_count == MAX_SAMPLES) begin
               close_window();
               windows_closed++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_filtered_value, rsp_position, rsp_is_outlier,
                     rsp_window_mean_q8, rsp_last_result};
            beats_seen++;
            if (rsp_is_outlier) outliers_seen++;
            if (expected_beats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected beat: value %0d pos %0d", rsp_filtered_value,
                           rsp_position);
            end else begin
               want = expected_beats.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch exp %0d %0d %0b %0d %0b got %0d %0d %0b %0d %0b",
                              want.filtered, want.position, want.outlier, want.mean_q8,
                              want.last, seen.filtered, seen.position, seen.outlier,
                              seen.mean_q8, seen.last);
               end
            end
         end
      end
   end
endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// random and directed windows through the outlier replacement filter
// ----------------------------------------------------------------------------
// windows of 1 to 16 samples are pushed in phases, each phase with its own
// cluster gap; a checker beside the block predicts and compares every beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import cor_pkg::*;

   localparam int CYCLE_LIMIT = 50000;

   logic                          clock = 0;
   logic                          reset = 1;
   logic                          csr_write_enable = 0;
   logic [GAP_BITS-1:0]           csr_write_data = '0;
   logic                          req_valid = 0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_value = '0;
   logic                          req_last_sample = 0;
   logic                          rsp_valid;
   logic                          rsp_ready = 0;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_value;
   logic [IDX_BITS-1:0]           rsp_position;
   logic                          rsp_is_outlier;
   logic signed [MEAN_BITS-1:0]   rsp_window_mean_q8;
   logic                          rsp_last_result;

   int mismatch_count, pending_beats, beats_seen, windows_closed, outliers_seen;
   int cycle_count = 0;
   int beats_sent = 0;
   bit quiet_tail = 0;      // no idling on either side near the end
   bit hold_off_wanted = 0; // long receiver stall request

   always #5 clock = ~clock;

   cluster_outlier_replace_filter i_dut (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_ready, .req_sample_value, .req_last_sample,
      .rsp_valid, .rsp_ready, .rsp_filtered_value, .rsp_position,
      .rsp_is_outlier, .rsp_window_mean_q8, .rsp_last_result
   );

   cor_checker i_checker (.*);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         if (hold_off_wanted) begin
            rsp_ready <= 0;
            repeat (400) @(negedge clock);
            hold_off_wanted = 0;
         end else if (!quiet_tail && $urandom_range(3) == 0) begin
            stall = $urandom_range(11, 1);
            rsp_ready <= 0;
            repeat (stall) @(negedge clock);
         end else begin
            rsp_ready <= 1;
            @(negedge clock);
         end
      end
   end

   // one beat on the req channel, holding valid until taken; valid is
   // dropped by the next idle burst or by the caller
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                              input logic last);
      begin
         if (!quiet_tail && $urandom_range(4) == 0) begin
            req_valid <= 0;
            repeat ($urandom_range(11, 1)) @(negedge clock);
         end
         req_valid <= 1;
         req_sample_value <= value;
         req_last_sample <= last;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
         beats_sent++;
      end
   endtask

   task automatic send_window(input longint values[$], input bit mark_last);
      int k;
      begin
         for (k = 0; k < values.size(); k++)
            send_sample(SAMPLE_BITS'(values[k]), mark_last && k == values.size() - 1);
      end
   endtask

   // random window: mostly a tight cluster plus a few far values
   task automatic random_window();
      longint vals[$];
      longint center;
      int count, k, spread;
      begin
         count = ($urandom_range(5) == 0) ? 16 : $urandom_range(8, 1);
         center = $signed($urandom_range(65535)) - 32768;
         spread = $urandom_range(20);
         for (k = 0; k < count; k++) begin
            if ($urandom_range(3) == 0)
               vals.push_back(longint'($signed($urandom_range(65535))) - 32768);
            else begin
               longint v;
               v = center + $signed($urandom_range(2 * spread)) - spread;
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               vals.push_back(v);
            end
         end
         send_window(vals, count < 16 || $urandom_range(1));
      end
   endtask

   // register write only when idle: all beats drained, then block latency
   task automatic set_gap(input logic [GAP_BITS-1:0] gap);
      begin
         req_valid <= 0;
         while (pending_beats != 0) @(negedge clock);
         repeat (20) @(negedge clock);
         csr_write_enable <= 1;
         csr_write_data <= gap;
         @(negedge clock);
         csr_write_enable <= 0;
      end
   endtask

   initial begin
      int k, phase;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed windows at the reset gap
      send_window('{32767}, 1);
      send_window('{-32768, 32767}, 1);
      send_window('{5, 5, 5, 1000}, 1);
      send_window('{-10, 0, 10, 20}, 1);      // size tie picks lower run
      send_window('{-32768, -32768, -32767, 0, 32767}, 1);
      send_window('{-1, -2, -3, 30000, -3, -30000}, 1);

      // full window with no mark closes on its own
      send_window('{1, 2, 3, 4, 5, 6, 7, 8, 100, 200, 300, 9, 10, 11, 12, 13}, 0);

      // long receiver stall while the sender keeps offering
      hold_off_wanted = 1;
      repeat (3) random_window();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_gap('0);
            1: set_gap(16'hFFFF);
            2: set_gap(GAP_BITS'($urandom_range(300)));
            default: set_gap(GAP_BITS'($urandom_range(65535)));
         endcase
         if (phase == 0) send_window('{3, 3, 4, 4, 4}, 1);
         if (phase == 3) quiet_tail = 1;
         for (k = 0; k < 2; k++) random_window();
      end

      req_valid <= 0;
      while (pending_beats != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("run covered %0d samples in %0d windows, %0d result beats, %0d outliers",
               beats_sent, windows_closed, beats_seen, outliers_seen);
      $display("gap settings: reset, zero, all ones and two random values");
      if (mismatch_count == 0 && pending_beats == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

[sim.f]
hdl/cor_pkg.sv
hdl/cor_ram.sv
hdl/cor_sorter.sv
hdl/cor_divider.sv
hdl/cluster_outlier_replace_filter.sv
bench/cor_checker.sv
bench/tb.sv
